>>> src/fdsp_pkg.sv
package fdsp_pkg;

  localparam int unsigned MaxChars = 5;
  localparam int unsigned CountW   = 3;
  localparam int unsigned MagW     = 17;
  localparam int unsigned ThrW     = 7;
  localparam int unsigned SpeedW   = 16;

  localparam logic [7:0] ChStart = 8'h40;
  localparam logic [7:0] ChEnd   = 8'h24;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [MagW-1:0]  MagCap      = 17'd32768;
  localparam logic [MagW-1:0]  PosMax      = 17'd32767;
  localparam logic [7:0]       ThrReset    = 8'd20;

  typedef struct packed {
    logic              in_packet;
    logic [CountW-1:0] char_count;
    logic [MagW-1:0]   magnitude;
    logic              is_negative;
    logic              digit_seen;
    logic              number_ended;
  } parse_state_t;

endpackage

>>> src/framed_decimal_speed_parser_unit.sv
// an input transfer is held in the input register, and its result then goes into the output register
// throughput: one byte per cycle while the output is not stalled, set by the state update between
//   the input register and the result register
// reset (rst_ni, asynchronous, active low): parser idle outside any packet,
//   both registers empty, speed threshold back to 20
module framed_decimal_speed_parser_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          rx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [fdsp_pkg::SpeedW-1:0]  remote_speed_o,
  output logic                                above_threshold_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fdsp_pkg::ThrW-1:0]           cfg_speed_threshold_i
);

  logic                        byte_valid_q;
  logic [7:0]                  byte_q;
  logic [fdsp_pkg::ThrW-1:0]   thr_q;
  fdsp_pkg::parse_state_t      st_q, st_d;
  logic                        out_valid_q, out_valid_d;
  logic [fdsp_pkg::SpeedW-1:0] speed_q, speed_d;
  logic                        above_q, above_d;
  logic                        advance;
  logic                        emit;
  logic [19:0]                 mag_next;
  logic [fdsp_pkg::MagW-1:0]   mag_out;
  logic [10:0]                 thr_x10;

  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = byte_valid_q && !advance;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o       = out_valid_q;
  assign remote_speed_o    = speed_q;
  assign above_threshold_o = above_q;

  assign mag_next = {3'b000, st_q.magnitude} * 20'd10 + {12'd0, byte_q - fdsp_pkg::ChZero};
  assign thr_x10  = {1'b0, thr_q, 3'b000} + {3'b000, thr_q, 1'b0};

  always_comb begin
    st_d    = st_q;
    emit    = 1'b0;
    mag_out = st_q.magnitude;
    speed_d = st_q.magnitude[fdsp_pkg::SpeedW-1:0];
    if (st_q.is_negative) begin
      mag_out = st_q.magnitude;
      speed_d = 16'(~st_q.magnitude + 17'd1);
    end else if (st_q.magnitude > fdsp_pkg::PosMax) begin
      mag_out = fdsp_pkg::PosMax;
      speed_d = fdsp_pkg::PosMax[fdsp_pkg::SpeedW-1:0];
    end
    above_d = (mag_out > {6'd0, thr_x10});

    if (byte_valid_q) begin
      if (byte_q == fdsp_pkg::ChStart) begin
        st_d              = '0;
        st_d.in_packet    = 1'b1;
      end else if (st_q.in_packet) begin
        case (byte_q) inside
          fdsp_pkg::ChEnd: begin
            st_d.in_packet = 1'b0;
            emit = (st_q.char_count != '0) && st_q.digit_seen;
          end
          fdsp_pkg::ChMinus, [fdsp_pkg::ChZero:fdsp_pkg::ChNine]: begin
            if (st_q.char_count < fdsp_pkg::CountW'(fdsp_pkg::MaxChars)) begin
              st_d.char_count = st_q.char_count + 1'b1;
              if (st_q.number_ended) begin
                st_d.number_ended = 1'b1;
              end else if (byte_q == fdsp_pkg::ChMinus && st_q.char_count == '0) begin
                st_d.is_negative = 1'b1;
              end else if (byte_q != fdsp_pkg::ChMinus) begin
                st_d.digit_seen = 1'b1;
                st_d.magnitude  = (mag_next > {3'b000, fdsp_pkg::MagCap}) ?
                                  fdsp_pkg::MagCap : mag_next[fdsp_pkg::MagW-1:0];
              end else begin
                st_d.number_ended = 1'b1;
              end
            end else begin
              st_d.in_packet = 1'b0;
            end
          end
          default: begin
            st_d.in_packet = 1'b0;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      st_q         <= '0;
      thr_q        <= fdsp_pkg::ThrReset[fdsp_pkg::ThrW-1:0];
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_speed_threshold_i;
      end
      if (!in_stall_o) begin
        byte_valid_q <= in_valid_i;
      end
      if (advance) begin
        st_q <= st_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
    if (advance && emit) begin
      speed_q <= speed_d;
      above_q <= above_d;
    end
  end

endmodule
